@@ rtl/lrukv_pkg.sv @@
`default_nettype none

package lrukv_pkg;

    // Field widths fixed by the interface
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    // Capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes
    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_SET = 1'b1
    } cmd_t;

    // Outcome of one operation, held until the output register is free
    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/lrukv_ram.sv @@
`default_nettype none

module lrukv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/lru_key_value_cache_core.sv @@
`default_nettype none

// Fully associative key/value cache with least-recently-used replacement.
// Input channel (in_valid/in_ready) carries one word: cmd (get or set), key
// and value. Output channel (out_valid/out_ready) returns one word per input:
// found, read_value (get hit only, else zero) and evicted (set miss on a full
// store). cfg_we/cfg_data writes the capacity register; write it only while
// the block is idle. Capacity zero acts as one, above MAX_ENTRIES as
// MAX_ENTRIES.
// One item is handled at a time: in_ready stays low from acceptance until the
// result is handed on. A get that misses makes one pass over the entries,
// every other operation two, each pass one entry per cycle: a key scan
// through the key/value RAM and one comparator, then a recency update
// through the recency RAM read/write port.
// Reset empties the store (valid bits and entry count cleared) and loads
// capacity 16; RAM contents are not cleared. When the receiver stalls, the
// finished word waits in the output register; a following result waits in
// the sequencer until the output register frees, and in_ready stays low.
module lru_key_value_cache_core #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [lrukv_pkg::CAP_W-1:0]     cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            cmd,
    input  wire logic signed [lrukv_pkg::KEY_W-1:0] key,
    input  wire logic signed [lrukv_pkg::VAL_W-1:0] value,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 found,
    output logic signed [lrukv_pkg::VAL_W-1:0]   read_value,
    output logic                                 evicted
);

    localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RW  = IW;
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int CPW = (CW > lrukv_pkg::CAP_W) ? CW : lrukv_pkg::CAP_W;
    localparam int KW  = lrukv_pkg::KEY_W;
    localparam int VW  = lrukv_pkg::VAL_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPD,
        ST_FIN,
        ST_RESP
    } state_t;

    state_t                   state_reg, state_next;
    logic [lrukv_pkg::CAP_W-1:0] capacity_reg, capacity_next;
    logic [MAX_ENTRIES-1:0]   valid_reg, valid_next;
    logic [CW-1:0]            count_reg, count_next;

    logic                     cmd_reg, cmd_next;
    logic [KW-1:0]            key_reg, key_next;
    logic [VW-1:0]            value_reg, value_next;

    logic [CW-1:0]            issue_reg, issue_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic [IW-1:0]            rd_idx_reg, rd_idx_next;

    logic                     hit_reg, hit_next;
    logic [IW-1:0]            hit_idx_reg, hit_idx_next;
    logic [VW-1:0]            hit_val_reg, hit_val_next;
    logic [RW-1:0]            hit_rec_reg, hit_rec_next;
    logic                     free_ok_reg, free_ok_next;
    logic [IW-1:0]            free_idx_reg, free_idx_next;
    logic                     old_ok_reg, old_ok_next;
    logic [IW-1:0]            old_idx_reg, old_idx_next;
    logic [RW-1:0]            old_rec_reg, old_rec_next;

    logic [IW-1:0]            tgt_reg, tgt_next;
    logic [RW-1:0]            thr_reg, thr_next;
    logic                     incr_all_reg, incr_all_next;
    logic                     kv_wr_reg, kv_wr_next;
    logic                     grow_reg, grow_next;

    lrukv_pkg::result_t       res_reg, res_next;
    lrukv_pkg::result_t       out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;

    logic                     kv_we;
    logic [IW-1:0]            kv_waddr;
    logic [KW+VW-1:0]         kv_wdata;
    logic [KW+VW-1:0]         kv_rdata;
    logic                     rec_we;
    logic [IW-1:0]            rec_waddr;
    logic [RW-1:0]            rec_wdata;
    logic [RW-1:0]            rec_rdata;
    logic [IW-1:0]            raddr;

    logic [CPW-1:0]           cap_ext;
    logic [CPW-1:0]           eff_cap;
    logic                     full;
    logic                     key_eq;
    logic                     issue_done;

    assign raddr      = issue_reg[IW-1:0];
    assign issue_done = (issue_reg == CW'(MAX_ENTRIES));
    assign key_eq     = (kv_rdata[KW+VW-1:VW] == key_reg);

    // Clamp capacity into 1..MAX_ENTRIES
    always_comb
    begin
        cap_ext = CPW'(capacity_reg);
        if (cap_ext == '0)
        begin
            eff_cap = CPW'(1);
        end
        else if (cap_ext > CPW'(MAX_ENTRIES))
        begin
            eff_cap = CPW'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
        full = (CPW'(count_reg) >= eff_cap);
    end

    // Key and value share one RAM word
    lrukv_ram #(
        .WIDTH (KW + VW),
        .DEPTH (MAX_ENTRIES)
    ) u_kv_ram (
        .clk   (clk),
        .we    (kv_we),
        .waddr (kv_waddr),
        .wdata (kv_wdata),
        .raddr (raddr),
        .rdata (kv_rdata)
    );

    // Recency rank per entry, 0 is most recent
    lrukv_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_ENTRIES)
    ) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (rec_wdata),
        .raddr (raddr),
        .rdata (rec_rdata)
    );

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        capacity_next  = capacity_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        value_next     = value_reg;
        issue_next     = issue_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_val_next   = hit_val_reg;
        hit_rec_next   = hit_rec_reg;
        free_ok_next   = free_ok_reg;
        free_idx_next  = free_idx_reg;
        old_ok_next    = old_ok_reg;
        old_idx_next   = old_idx_reg;
        old_rec_next   = old_rec_reg;
        tgt_next       = tgt_reg;
        thr_next       = thr_reg;
        incr_all_next  = incr_all_reg;
        kv_wr_next     = kv_wr_reg;
        grow_next      = grow_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kv_we          = 1'b0;
        kv_waddr       = tgt_reg;
        kv_wdata       = {key_reg, value_reg};
        rec_we         = 1'b0;
        rec_waddr      = rd_idx_reg;
        rec_wdata      = '0;

        if (cfg_we)
        begin
            capacity_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                // Take the word and clear the scan results
                if (in_valid)
                begin
                    cmd_next     = cmd;
                    key_next     = key;
                    value_next   = value;
                    issue_next   = '0;
                    hit_next     = 1'b0;
                    free_ok_next = 1'b0;
                    old_ok_next  = 1'b0;
                    state_next   = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Issue one read per cycle
                if (!issue_done)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = raddr;
                    issue_next  = issue_reg + CW'(1);
                end
                // Compare the entry read last cycle
                if (rd_vld_reg)
                begin
                    if (valid_reg[rd_idx_reg])
                    begin
                        if (key_eq && !hit_reg)
                        begin
                            hit_next     = 1'b1;
                            hit_idx_next = rd_idx_reg;
                            hit_val_next = kv_rdata[VW-1:0];
                            hit_rec_next = rec_rdata;
                        end
                        if (!old_ok_reg || (rec_rdata > old_rec_reg))
                        begin
                            old_ok_next  = 1'b1;
                            old_idx_next = rd_idx_reg;
                            old_rec_next = rec_rdata;
                        end
                    end
                    else if (!free_ok_reg)
                    begin
                        free_ok_next  = 1'b1;
                        free_idx_next = rd_idx_reg;
                    end
                end
                if (issue_done && !rd_vld_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                issue_next = '0;
                res_next   = '0;
                if (hit_reg)
                begin
                    // Hit: move the entry to the front
                    res_next.found = 1'b1;
                    if (cmd_reg == lrukv_pkg::CMD_GET)
                    begin
                        res_next.read_value = hit_val_reg;
                    end
                    tgt_next      = hit_idx_reg;
                    thr_next      = hit_rec_reg;
                    incr_all_next = 1'b0;
                    kv_wr_next    = (cmd_reg == lrukv_pkg::CMD_SET);
                    grow_next     = 1'b0;
                    state_next    = ST_UPD;
                end
                else if (cmd_reg == lrukv_pkg::CMD_SET)
                begin
                    // Miss on set: reuse the oldest slot when full
                    incr_all_next = 1'b1;
                    kv_wr_next    = 1'b1;
                    if (full)
                    begin
                        tgt_next         = old_idx_reg;
                        res_next.evicted = 1'b1;
                        grow_next        = 1'b0;
                    end
                    else
                    begin
                        tgt_next  = free_idx_reg;
                        grow_next = 1'b1;
                    end
                    state_next = ST_UPD;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end

            ST_UPD:
            begin
                if (!issue_done)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = raddr;
                    issue_next  = issue_reg + CW'(1);
                end
                // Age entries that were more recent than the target, or all valid entries on a set miss
                if (rd_vld_reg)
                begin
                    if (rd_idx_reg == tgt_reg)
                    begin
                        rec_we    = 1'b1;
                        rec_wdata = '0;
                    end
                    else if (valid_reg[rd_idx_reg] && (incr_all_reg || (rec_rdata < thr_reg)))
                    begin
                        rec_we    = 1'b1;
                        rec_wdata = rec_rdata + RW'(1);
                    end
                end
                if (issue_done && !rd_vld_reg)
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                // Commit key/value and occupancy
                kv_we               = kv_wr_reg;
                valid_next[tgt_reg] = 1'b1;
                if (grow_reg)
                begin
                    count_next = count_reg + CW'(1);
                end
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                // Hand the result to the output register once it frees
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            capacity_reg  <= lrukv_pkg::CAP_RESET;
            valid_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            capacity_reg  <= capacity_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            rd_vld_reg    <= rd_vld_next;
        end
    end

    // Payload and scan bookkeeping
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        value_reg    <= value_next;
        issue_reg    <= issue_next;
        rd_idx_reg   <= rd_idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_val_reg  <= hit_val_next;
        hit_rec_reg  <= hit_rec_next;
        free_ok_reg  <= free_ok_next;
        free_idx_reg <= free_idx_next;
        old_ok_reg   <= old_ok_next;
        old_idx_reg  <= old_idx_next;
        old_rec_reg  <= old_rec_next;
        tgt_reg      <= tgt_next;
        thr_reg      <= thr_next;
        incr_all_reg <= incr_all_next;
        kv_wr_reg    <= kv_wr_next;
        grow_reg     <= grow_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign found      = out_reg.found;
    assign read_value = out_reg.read_value;
    assign evicted    = out_reg.evicted;

endmodule

`default_nettype wire
